>>> design/clem_pkg.sv
package clem_pkg;

  localparam int unsigned KIND_W = 3;
  localparam logic [2:0] KIND_LOAD_DIFF = 3'd0;
  localparam logic [2:0] KIND_LOAD_ABIL = 3'd1;
  localparam logic [2:0] KIND_E_REC     = 3'd2;
  localparam logic [2:0] KIND_ITEM_UPD  = 3'd3;
  localparam logic [2:0] KIND_WORK_UPD  = 3'd4;

  localparam logic [1:0] RES_POSTERIOR = 2'd0;
  localparam logic [1:0] RES_DIFF      = 2'd1;
  localparam logic [1:0] RES_ABIL      = 2'd2;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [15:0] LR_RESET = 16'd328;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] item_index;
    logic [5:0]  worker_index;
    logic        label;
    logic        last_in_group;
    logic [15:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] result_index;
    logic [15:0] posterior_value;
    logic [15:0] updated_value;
  } out_item_t;

  // piecewise-linear sigmoid on a Q8.24 product, result clamped to [1, 65535]
  function automatic logic [16:0] sigmoid_q16(input logic signed [31:0] p);
    logic [31:0] m;
    logic [16:0] y;
    logic [16:0] s;
    begin
      m = p[31] ? 32'(-p) : 32'(p);
      if (m >= 32'd83886080) y = 17'd65536;
      else if (m >= 32'd39845888) y = 17'(m >> 13) + 17'd55296;
      else if (m >= 32'd16777216) y = 17'(m >> 11) + 17'd40960;
      else y = 17'(m >> 10) + 17'd32768;
      s = p[31] ? 17'd65536 - y : y;
      if (s < 17'd1) s = 17'd1;
      if (s > 17'd65535) s = 17'd65535;
      sigmoid_q16 = s;
    end
  endfunction

endpackage

>>> design/clem_if.sv
interface clem_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> design/clem_front.sv
// accepts transactions, drops unknown kinds, feeds a two-entry queue
module clem_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  clem_pkg::in_item_t  in_data_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output clem_pkg::in_item_t  q_data_o
);
  clem_pkg::in_item_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, known;

  assign known = in_data_i.kind <= clem_pkg::KIND_WORK_UPD;
  assign in_ready_o = cnt_q != 2'd2;
  assign push = in_valid_i && in_ready_o && known;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

>>> design/clem_back.sv
// sequencer: read tables, multiply, sigmoid, update likelihoods or gradient,
// divide at group end, write back and emit a result
module clem_back #(
  parameter int unsigned ITEM_W = 16,
  parameter int unsigned WORK_W = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  clem_pkg::in_item_t q_data_i,
  input  logic [15:0]        lr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output clem_pkg::out_item_t out_data_o
);
  localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_MUL = 4'd2, S_SIG = 4'd3,
    S_E1 = 4'd4, S_E2 = 4'd5, S_NORM = 4'd6, S_DIV = 4'd7, S_M1 = 4'd8,
    S_M2 = 4'd9, S_M3 = 4'd10, S_G1 = 4'd11, S_G2 = 4'd12, S_OUT = 4'd13;

  logic [15:0] diff_mem [2**ITEM_W];
  logic [15:0] abil_mem [2**WORK_W];
  logic [15:0] post_mem [2**ITEM_W];

  logic [3:0]  st_q;
  clem_pkg::in_item_t cur_q;
  logic [ITEM_W-1:0] it;
  logic [WORK_W-1:0] wk;
  logic signed [15:0] d_q, a_q;
  logic [15:0] p_q;
  logic signed [31:0] prod_q;
  logic [16:0] s_q;
  logic [31:0] lt_q, lf_q;
  logic [47:0] mt_q, mf_q;
  logic signed [31:0] gs_q;
  logic [31:0] t1_q;
  logic [47:0] mag_q;
  logic        neg_q;
  logic [32:0] den_q, rem_q;
  logic [15:0] quo_q;
  logic [4:0]  dcnt_q;
  logic [47:0] g_q;
  clem_pkg::out_item_t pend_q;
  clem_pkg::out_item_t res_q;
  logic        ov_q;

  assign it = cur_q.item_index[ITEM_W-1:0];
  assign wk = cur_q.worker_index[WORK_W-1:0];
  assign q_pop_o = (st_q == S_IDLE) && q_valid_i;
  assign out_valid_o = ov_q;
  assign out_data_o = res_q;

  logic [16:0] c_w, ft_w, ff_w;
  logic [31:0] mx_w;
  logic [33:0] rtry_w;
  logic signed [16:0] e_w;
  logic [15:0] av_w;
  logic [16:0] ae_w;
  logic signed [33:0] acc_w;
  logic [31:0] ag_w;
  logic signed [17:0] nv_w;
  logic [15:0] nsat_w;
  logic [15:0] qsat_w;

  always_comb begin
    c_w = 17'd65536 - s_q;
    ft_w = cur_q.label ? s_q : c_w;
    ff_w = cur_q.label ? c_w : s_q;
    mx_w = (lt_q > lf_q) ? lt_q : lf_q;
    rtry_w = {rem_q, 1'b0};
    e_w = 17'sd2 * $signed({1'b0, p_q}) - 17'sd65536;
    av_w = cur_q.kind == clem_pkg::KIND_ITEM_UPD ?
           (a_q[15] ? 16'(-a_q) : 16'(a_q)) : (d_q[15] ? 16'(-d_q) : 16'(d_q));
    ae_w = e_w[16] ? 17'(-e_w) : 17'(e_w);
    acc_w = neg_q ? 34'(gs_q) - $signed({10'd0, mag_q[47:24]})
                  : 34'(gs_q) + $signed({10'd0, mag_q[47:24]});
    ag_w = gs_q[31] ? 32'(-gs_q) : 32'(gs_q);
    nv_w = 18'(cur_q.kind == clem_pkg::KIND_ITEM_UPD ? d_q : a_q) +
           (gs_q[31] ? -$signed({1'b0, g_q[40:24]}) : $signed({1'b0, g_q[40:24]}));
    if (g_q[47:41] != 7'd0) nv_w = gs_q[31] ? -18'sd65536 : 18'sd65536;
    if (nv_w > 18'sd32767) nsat_w = 16'h7fff;
    else if (nv_w < -18'sd32768) nsat_w = 16'h8000;
    else nsat_w = nv_w[15:0];
    qsat_w = quo_q;
  end

  // table writes and registered reads
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
      if (q_data_i.kind == clem_pkg::KIND_LOAD_DIFF)
        diff_mem[q_data_i.item_index[ITEM_W-1:0]] <= q_data_i.load_value;
      if (q_data_i.kind == clem_pkg::KIND_LOAD_ABIL)
        abil_mem[q_data_i.worker_index[WORK_W-1:0]] <= q_data_i.load_value;
    end
    if (st_q == S_READ) begin
      d_q <= diff_mem[it];
      a_q <= abil_mem[wk];
      p_q <= post_mem[it];
    end
    if (st_q == S_DIV && dcnt_q == 5'd0) post_mem[it] <= qsat_w;
    if (st_q == S_G2) begin
      if (cur_q.kind == clem_pkg::KIND_ITEM_UPD) diff_mem[it] <= nsat_w;
      else abil_mem[wk] <= nsat_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      lt_q <= clem_pkg::ONE_Q31;
      lf_q <= clem_pkg::ONE_Q31;
      gs_q <= '0;
      ov_q <= 1'b0;
    end else begin
      // output register: load a new result once the slot is free
      if (st_q == S_OUT && (!ov_q || out_ready_i)) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (q_pop_o && (q_data_i.kind == clem_pkg::KIND_E_REC ||
                          q_data_i.kind == clem_pkg::KIND_ITEM_UPD ||
                          q_data_i.kind == clem_pkg::KIND_WORK_UPD)) st_q <= S_READ;
        end
        S_READ: st_q <= S_MUL;
        S_MUL: begin
          prod_q <= d_q * a_q;
          st_q <= S_SIG;
        end
        S_SIG: begin
          s_q <= clem_pkg::sigmoid_q16(prod_q);
          st_q <= cur_q.kind == clem_pkg::KIND_E_REC ? S_E1 : S_M1;
        end
        S_E1: begin
          mt_q <= lt_q * ft_w;
          mf_q <= lf_q * ff_w;
          st_q <= S_E2;
        end
        S_E2: begin
          lt_q <= mt_q[47:16];
          lf_q <= mf_q[47:16];
          st_q <= S_NORM;
        end
        S_NORM: begin
          // one bit of shift per cycle
          if (mx_w != 32'd0 && !mx_w[31]) begin
            lt_q <= lt_q << 1;
            lf_q <= lf_q << 1;
          end else if (cur_q.last_in_group) begin
            den_q <= {1'b0, lt_q} + {1'b0, lf_q};
            rem_q <= {1'b0, lt_q};
            quo_q <= '0;
            dcnt_q <= 5'd16;
            st_q <= S_DIV;
          end else st_q <= S_IDLE;
        end
        S_DIV: begin
          // restoring divide, quotient saturates naturally at 16 bits
          if (dcnt_q != 5'd0) begin
            if (rtry_w >= {1'b0, den_q}) begin
              rem_q <= 33'(rtry_w - {1'b0, den_q});
              quo_q <= {quo_q[14:0], 1'b1};
            end else begin
              rem_q <= rtry_w[32:0];
              quo_q <= {quo_q[14:0], 1'b0};
            end
            dcnt_q <= dcnt_q - 5'd1;
          end else begin
            pend_q <= '{clem_pkg::RES_POSTERIOR, cur_q.item_index & 16'(2**ITEM_W - 1),
                        qsat_w, 16'd0};
            lt_q <= clem_pkg::ONE_Q31;
            lf_q <= clem_pkg::ONE_Q31;
            st_q <= S_OUT;
          end
        end
        S_M1: begin
          t1_q <= av_w * c_w[15:0] + (c_w[16] ? 32'(av_w) << 16 : 32'd0);
          neg_q <= (cur_q.kind == clem_pkg::KIND_ITEM_UPD ? a_q[15] : d_q[15]) ^
                   e_w[16] ^ ~cur_q.label;
          st_q <= S_M2;
        end
        S_M2: begin
          mag_q <= t1_q * ae_w;
          st_q <= S_M3;
        end
        S_M3: begin
          if (acc_w > 34'sh7fffffff) gs_q <= 32'sh7fffffff;
          else if (acc_w < -34'sh80000000) gs_q <= 32'sh80000000;
          else gs_q <= acc_w[31:0];
          st_q <= cur_q.last_in_group ? S_G1 : S_IDLE;
        end
        S_G1: begin
          g_q <= ag_w * lr_i;
          st_q <= S_G2;
        end
        S_G2: begin
          if (cur_q.kind == clem_pkg::KIND_ITEM_UPD)
            pend_q <= '{clem_pkg::RES_DIFF, cur_q.item_index & 16'(2**ITEM_W - 1),
                        16'd0, nsat_w};
          else
            pend_q <= '{clem_pkg::RES_ABIL, 16'(wk), 16'd0, nsat_w};
          gs_q <= '0;
          st_q <= S_OUT;
        end
        S_OUT: begin
          if (!ov_q || out_ready_i) begin
            res_q <= pend_q;
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/crowd_label_em_aggregator_core.sv
// Crowd-label EM aggregator. Transactions enter a two-entry queue and are
// run one at a time by a sequencer: a load writes its table; an E record
// updates the likelihoods and renormalizes them by single-bit shifts; an
// M record updates the gradient. A group end adds the bit-serial posterior
// divide or the table update, then hands the result to the output
// register, which waits while an earlier result is still unaccepted. A
// posterior of exactly one reads as 65535. The learning rate may be written
// only while the block is idle. Tables are undefined until loaded.
module crowd_label_em_aggregator_core #(
  parameter int unsigned ITEM_W = 16,
  parameter int unsigned WORK_W = 6
) (
  input  logic clk_i,
  input  logic rst_ni,
  clem_if.sink   in_ch,
  clem_if.sink   cfg_ch,
  clem_if.source out_ch
);
  logic [15:0] lr_q;
  logic        q_valid, q_pop;
  clem_pkg::in_item_t q_data;
  clem_pkg::out_item_t od;

  // learning rate register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lr_q <= clem_pkg::LR_RESET;
    else if (cfg_ch.valid) lr_q <= cfg_ch.data[15:0];
  end

  clem_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .in_data_i(clem_pkg::in_item_t'(in_ch.data[42:0])),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  clem_back #(.ITEM_W(ITEM_W), .WORK_W(WORK_W)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .lr_i(lr_q),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_o(od)
  );
  assign out_ch.data = 50'(od);
endmodule

>>> tb/tb_crowd_label_em_aggregator_core.sv
`timescale 1ns / 1ps

module tb_crowd_label_em_aggregator_core;

  localparam int unsigned POOL_N = 24;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned PHASE_RECORDS = 270;
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam logic [31:0] SIG_SAT = 32'd83886080;
  localparam logic [31:0] SIG_MID = 32'd39845888;
  localparam logic [31:0] SIG_ONE = 32'd16777216;

  logic clk_i;
  logic rst_ni;

  clem_if #(.W($bits(clem_pkg::in_item_t))) in_ch();
  clem_if #(.W(16)) cfg_ch();
  clem_if #(.W($bits(clem_pkg::out_item_t))) out_ch();

  crowd_label_em_aggregator_core DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_ch(in_ch),
    .cfg_ch(cfg_ch),
    .out_ch(out_ch)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // shadow state of the aggregator
  logic [15:0] diff_shadow [65536];
  logic [15:0] abil_shadow [64];
  logic [15:0] post_shadow [65536];
  logic [31:0] lik_true;
  logic [31:0] lik_false;
  logic signed [31:0] grad_acc;
  logic [15:0] step_rate;

  clem_pkg::out_item_t expected_results[$];
  clem_pkg::in_item_t pending_records[$];
  int unsigned error_count;
  int unsigned records_made;
  logic [15:0] item_pool [POOL_N];

  logic in_fire, out_fire;
  int unsigned in_gap, out_stall, idle_cycles;
  bit quiet;

  function automatic int unsigned draw_wait();
    draw_wait = quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // piecewise-linear logistic of difficulty*ability, clamped to [1, 65535]
  function automatic logic [16:0] logistic_q16(logic signed [15:0] d, logic signed [15:0] a);
    logic signed [31:0] prod;
    logic [31:0] mag;
    logic [16:0] y;
    prod = d * a;
    mag = prod < 0 ? -prod : prod;
    if (mag >= SIG_SAT) y = 17'h10000;
    else if (mag >= SIG_MID) y = 17'(mag >> 13) + 17'd55296;
    else if (mag >= SIG_ONE) y = 17'(mag >> 11) + 17'd40960;
    else y = 17'(mag >> 10) + 17'd32768;
    if (prod < 0) y = 17'h10000 - y;
    if (y == 17'd0) y = 17'd1;
    if (y == 17'h10000) y = 17'd65535;
    logistic_q16 = y;
  endfunction

  // one record through the shadow state, queueing the result it yields
  task automatic absorb_record(clem_pkg::in_item_t r);
    logic signed [15:0] d, a, val;
    logic [16:0] s, c, ft, ff;
    logic [31:0] mx;
    logic [32:0] den;
    longint q, e, av, ae, mag, sum, g, nv;
    bit neg;
    clem_pkg::out_item_t res;
    d = diff_shadow[r.item_index];
    a = abil_shadow[r.worker_index];
    res = '0;
    case (r.kind)
      clem_pkg::KIND_LOAD_DIFF: diff_shadow[r.item_index] = r.load_value;
      clem_pkg::KIND_LOAD_ABIL: abil_shadow[r.worker_index] = r.load_value;
      clem_pkg::KIND_E_REC: begin
        s = logistic_q16(d, a);
        c = 17'h10000 - s;
        ft = r.label ? s : c;
        ff = r.label ? c : s;
        lik_true = 32'((64'(lik_true) * ft) >> 16);
        lik_false = 32'((64'(lik_false) * ff) >> 16);
        mx = lik_true > lik_false ? lik_true : lik_false;
        while (mx != 0 && !mx[31]) begin
          lik_true = lik_true << 1;
          lik_false = lik_false << 1;
          mx = mx << 1;
        end
        if (r.last_in_group) begin
          den = 33'(lik_true) + 33'(lik_false);
          q = den == 0 ? 0 : (longint'(lik_true) << 16) / longint'(den);
          if (q > 65535) q = 65535;
          post_shadow[r.item_index] = 16'(q);
          res.result_kind = clem_pkg::RES_POSTERIOR;
          res.result_index = r.item_index;
          res.posterior_value = 16'(q);
          expected_results.push_back(res);
          lik_true = clem_pkg::ONE_Q31;
          lik_false = clem_pkg::ONE_Q31;
        end
      end
      clem_pkg::KIND_ITEM_UPD, clem_pkg::KIND_WORK_UPD: begin
        s = logistic_q16(d, a);
        c = 17'h10000 - s;
        val = r.kind == clem_pkg::KIND_ITEM_UPD ? a : d;
        e = 2 * longint'(post_shadow[r.item_index]) - 65536;
        av = val < 0 ? -longint'(val) : longint'(val);
        ae = e < 0 ? -e : e;
        mag = (av * longint'(c) * ae) >>> 24;
        neg = (val < 0) ^ (e < 0) ^ (r.label == 1'b0);
        sum = longint'(grad_acc) + (neg ? -mag : mag);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        grad_acc = 32'(sum);
        if (r.last_in_group) begin
          g = grad_acc;
          mag = ((g < 0 ? -g : g) * longint'(step_rate)) >>> 24;
          nv = longint'(r.kind == clem_pkg::KIND_ITEM_UPD ? d : a) + (g < 0 ? -mag : mag);
          if (nv > 32767) nv = 32767;
          if (nv < -32768) nv = -32768;
          if (r.kind == clem_pkg::KIND_ITEM_UPD) begin
            diff_shadow[r.item_index] = 16'(nv);
            res.result_kind = clem_pkg::RES_DIFF;
            res.result_index = r.item_index;
          end else begin
            abil_shadow[r.worker_index] = 16'(nv);
            res.result_kind = clem_pkg::RES_ABIL;
            res.result_index = 16'(r.worker_index);
          end
          res.updated_value = 16'(nv);
          expected_results.push_back(res);
          grad_acc = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic check_result(clem_pkg::out_item_t got);
    clem_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      $display("unexpected result transaction kind %0d index %0d",
               got.result_kind, got.result_index);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.result_kind !== want.result_kind)
        report_mismatch("result_kind", 16'(got.result_kind), 16'(want.result_kind));
      if (got.result_index !== want.result_index)
        report_mismatch("result_index", got.result_index, want.result_index);
      if (got.posterior_value !== want.posterior_value)
        report_mismatch("posterior_value", got.posterior_value, want.posterior_value);
      if (got.updated_value !== want.updated_value)
        report_mismatch("updated_value", got.updated_value, want.updated_value);
    end
  endtask

  // sampling at the rising edge: prediction, checking, watchdog
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
    out_fire <= rst_ni && out_ch.valid && out_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) absorb_record(clem_pkg::in_item_t'(in_ch.data));
      if (out_ch.valid && out_ch.ready) check_result(clem_pkg::out_item_t'(out_ch.data));
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if ($urandom_range(0, 199) == 0) quiet = !quiet;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[crowd_label_em_aggregator_core] ERROR");
        $finish;
      end
    end
  end

  // record driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_records.size() > 0) begin
        in_ch.data <= pending_records.pop_front();
        in_ch.valid <= 1'b1;
        in_gap = draw_wait();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_fire) out_stall = draw_wait();
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_rec(logic [2:0] kind, logic [15:0] item, logic [5:0] worker,
                          logic label, logic last, logic [15:0] value);
    clem_pkg::in_item_t r;
    r.kind = kind;
    r.item_index = item;
    r.worker_index = worker;
    r.label = label;
    r.last_in_group = last;
    r.load_value = value;
    pending_records.push_back(r);
    if (kind <= clem_pkg::KIND_WORK_UPD) records_made++;
  endtask

  function automatic logic [15:0] random_value();
    case ($urandom_range(0, 5))
      0: random_value = 16'h8000;
      1: random_value = 16'h7fff;
      default: random_value = 16'($urandom);
    endcase
  endfunction

  // one random group; mostly well-formed, some broken or noise
  task automatic make_group();
    int unsigned pick, len;
    logic [15:0] item;
    logic [5:0] worker;
    bit broken;
    pick = $urandom_range(0, 99);
    len = $urandom_range(1, 6);
    broken = $urandom_range(0, 9) == 0;
    item = item_pool[$urandom_range(0, POOL_N - 1)];
    worker = 6'($urandom_range(0, 63));
    if (pick < 8) begin
      push_rec(clem_pkg::KIND_LOAD_DIFF, item, 6'($urandom), 1'($urandom), 1'($urandom),
               random_value());
    end else if (pick < 14) begin
      push_rec(clem_pkg::KIND_LOAD_ABIL, 16'($urandom), worker, 1'($urandom), 1'($urandom),
               random_value());
    end else if (pick < 18) begin
      push_rec(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)), 16'($urandom),
               6'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
    end else if (pick < 50) begin
      for (int i = 0; i < len; i++)
        push_rec(clem_pkg::KIND_E_REC, item, 6'($urandom), 1'($urandom),
                 i == len - 1 && !broken, 16'($urandom));
    end else if (pick < 75) begin
      for (int i = 0; i < len; i++)
        push_rec(clem_pkg::KIND_ITEM_UPD, item, 6'($urandom), 1'($urandom),
                 i == len - 1 && !broken, 16'($urandom));
    end else begin
      for (int i = 0; i < len; i++)
        push_rec(clem_pkg::KIND_WORK_UPD, item_pool[$urandom_range(0, POOL_N - 1)], worker,
                 1'($urandom), i == len - 1 && !broken, 16'($urandom));
    end
  endtask

  // wait until every record went in and every result came back
  task automatic drain();
    while (pending_records.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [15:0] rate);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= rate;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    step_rate = rate;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] rates [4];
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    in_fire = 1'b0;
    out_fire = 1'b0;
    in_gap = 0;
    out_stall = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    error_count = 0;
    records_made = 0;
    lik_true = clem_pkg::ONE_Q31;
    lik_false = clem_pkg::ONE_Q31;
    grad_acc = 0;
    step_rate = clem_pkg::LR_RESET;
    foreach (diff_shadow[i]) diff_shadow[i] = '0;
    foreach (post_shadow[i]) post_shadow[i] = '0;
    foreach (abil_shadow[i]) abil_shadow[i] = '0;
    item_pool[0] = 16'h0000;
    item_pool[1] = 16'hffff;
    for (int i = 2; i < POOL_N; i++) item_pool[i] = 16'($urandom);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // setup: every ability, every pool difficulty, one posterior per pool item
    for (int w = 0; w < 64; w++)
      push_rec(clem_pkg::KIND_LOAD_ABIL, 16'($urandom), 6'(w), 1'($urandom), 1'($urandom),
               w == 0 ? 16'h8000 : w == 63 ? 16'h7fff : w == 1 ? 16'h0000 : random_value());
    push_rec(clem_pkg::KIND_LOAD_DIFF, item_pool[0], 6'd0, 1'b0, 1'b0, 16'h7fff);
    push_rec(clem_pkg::KIND_LOAD_DIFF, item_pool[1], 6'd63, 1'b1, 1'b1, 16'h8000);
    for (int i = 2; i < POOL_N; i++)
      push_rec(clem_pkg::KIND_LOAD_DIFF, item_pool[i], 6'($urandom), 1'($urandom),
               1'($urandom), random_value());
    for (int i = 0; i < POOL_N; i++)
      push_rec(clem_pkg::KIND_E_REC, item_pool[i], 6'($urandom), 1'($urandom), 1'b1,
               16'($urandom));

    // vanishing likelihood: saturated sigmoid against the label
    for (int i = 0; i < 6; i++)
      push_rec(clem_pkg::KIND_E_REC, item_pool[0], 6'd63, 1'b0, i == 5, 16'h0000);
    // saturated sigmoid with the label
    push_rec(clem_pkg::KIND_E_REC, item_pool[0], 6'd63, 1'b1, 1'b1, 16'hffff);
    // negative product, zero ability
    push_rec(clem_pkg::KIND_E_REC, item_pool[1], 6'd63, 1'b1, 1'b0, 16'h0000);
    push_rec(clem_pkg::KIND_E_REC, item_pool[1], 6'd1, 1'b0, 1'b1, 16'h0000);
    // update groups of both kinds, extremes of value
    push_rec(clem_pkg::KIND_ITEM_UPD, item_pool[1], 6'd0, 1'b0, 1'b0, 16'h0000);
    push_rec(clem_pkg::KIND_ITEM_UPD, item_pool[1], 6'd63, 1'b1, 1'b1, 16'h0000);
    push_rec(clem_pkg::KIND_WORK_UPD, item_pool[0], 6'd63, 1'b1, 1'b0, 16'h0000);
    push_rec(clem_pkg::KIND_WORK_UPD, item_pool[1], 6'd63, 1'b0, 1'b1, 16'h0000);
    // unused kinds interleaved in an open group
    push_rec(clem_pkg::KIND_E_REC, item_pool[2], 6'd5, 1'b1, 1'b0, 16'h0000);
    for (logic [2:0] k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI && k != 3'd0; k++)
      push_rec(k, 16'hffff, 6'h3f, 1'b1, 1'b1, 16'hffff);
    push_rec(clem_pkg::KIND_E_REC, item_pool[2], 6'd6, 1'b0, 1'b1, 16'h0000);
    drain();

    // random phases across the rate extremes
    rates[0] = 16'hffff;
    rates[1] = 16'h0000;
    rates[2] = 16'($urandom);
    rates[3] = clem_pkg::LR_RESET;
    foreach (rates[p]) begin
      write_rate(rates[p]);
      records_made = 0;
      while (records_made < PHASE_RECORDS) make_group();
      drain();
    end

    if (error_count == 0)
      $display("[crowd_label_em_aggregator_core] OK");
    else
      $display("[crowd_label_em_aggregator_core] ERROR");
    $finish;
  end

endmodule
